// ===== hdl/pic_pkg.sv =====
// Package for the single 8259-style interrupt controller.
// Holds the item kinds, initialisation phases, command byte codes and priority helpers.
// No dependencies.
`timescale 1ns / 1ps

package pic_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_LINE  = 2'd2,
        FUNC_ACK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_ICW2  = 2'd1,
        PH_ICW3  = 2'd2,
        PH_ICW4  = 2'd3
    } phase_t;

    localparam logic       PORT_CMD       = 1'b0;
    localparam logic       PORT_DATA      = 1'b1;

    localparam logic [7:0] ICW1_FLAG      = 8'h10;
    localparam logic [7:0] OCW3_SEL_MASK  = 8'h18;
    localparam logic [7:0] OCW3_SEL_CODE  = 8'h08;
    localparam logic [7:0] EOI_SEL_MASK   = 8'he0;
    localparam logic [7:0] EOI_NONSPEC    = 8'h20;
    localparam logic [7:0] EOI_SPECIFIC   = 8'h60;
    localparam logic [7:0] VEC_BASE_MASK  = 8'hf8;
    localparam logic [7:0] VEC_BASE_RESET = 8'h08;
    localparam logic [7:0] MASK_RESET     = 8'hff;

    // Lowest set bit of a byte as a one-hot byte, zero when the byte is empty.
    function automatic logic [7:0] lowest_onehot(input logic [7:0] v);
        return v & (~v + 8'd1);
    endfunction

    // Index of the lowest set bit; meaningless when the byte is empty.
    function automatic logic [2:0] lowest_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Requests that are unmasked and above the highest-priority line in service.
    // With nothing in service the isolated bit is zero and the limit wraps to all ones.
    function automatic logic [7:0] eligible(input logic [7:0] irr,
                                            input logic [7:0] imr,
                                            input logic [7:0] isr);
        return irr & ~imr & (lowest_onehot(isr) - 8'd1);
    endfunction

endpackage

// ===== hdl/interrupt_controller_8259_single.sv =====
// Top level of the single 8259-style interrupt controller (fully nested mode).
// Depends on pic_pkg for item kinds, phases, command codes and priority helpers.
//
// Usage:
//   The item channel (item_valid / item_ready) carries one bus access or event per
//   word: a register read, a register write, a request line change or an interrupt
//   acknowledge. The result channel (result_valid / result_ready) returns exactly one
//   word per item, in order, with the read data, the vector, the idle status, the
//   interrupt output level and a snapshot of IMR, IRR, ISR and the line levels.
//   An accepted word sits in the input register; when it advances, the state update
//   and the result register load happen together. Throughput is one word per cycle
//   while the receiver takes each result; it is set by the single state update stage,
//   whose priority encode and mask logic is combinational.
//   When the receiver stalls, the result register holds its word and the input
//   register still takes one more word, after which item_ready falls until the
//   result is taken.
//   Reset sets IMR to all ones, clears IRR, ISR and line levels, sets the vector
//   base to 8, leaves initialisation in the ready phase and empties both registers.
`timescale 1ns / 1ps

module interrupt_controller_8259_single
    import pic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] func,
    input  logic       port,
    input  logic [7:0] write_data,
    input  logic [2:0] irq_line,
    input  logic       level,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_data,
    output logic [7:0] vector_out,
    output logic       status,
    output logic       int_pending,
    output logic [7:0] mask_reg,
    output logic [7:0] request_reg,
    output logic [7:0] service_reg,
    output logic [7:0] line_levels
);

    // Input register.
    logic       in_valid_reg;
    func_t      in_func_reg;
    logic       in_port_reg;
    logic [7:0] in_data_reg;
    logic [2:0] in_line_reg;
    logic       in_level_reg;

    // Controller state.
    logic [7:0] mask_bits_reg,    mask_bits_next;
    logic [7:0] request_bits_reg, request_bits_next;
    logic [7:0] service_bits_reg, service_bits_next;
    logic [7:0] line_state_reg,   line_state_next;
    logic [7:0] vector_base_reg,  vector_base_next;
    phase_t     phase_reg,        phase_next;
    logic       icw4_expected_reg, icw4_expected_next;
    logic       single_mode_reg,  single_mode_next;
    logic       readback_isr_reg, readback_isr_next;
    logic       auto_eoi_reg,     auto_eoi_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] rd_data_reg,  rd_data_next;
    logic [7:0] vector_reg,   vector_next;
    logic       idle_reg,     idle_next;
    logic       int_out_reg,  int_out_next;

    logic       advance;

    // The state stage moves a word on when the result register is empty or being taken.
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_func_reg  <= func_t'(func);
            in_port_reg  <= port;
            in_data_reg  <= write_data;
            in_line_reg  <= irq_line;
            in_level_reg <= level;
        end
    end

    always_comb
    begin
        logic [7:0] line_bit;
        logic [7:0] ack_pick;
        logic [7:0] eoi_bit;

        mask_bits_next     = mask_bits_reg;
        request_bits_next  = request_bits_reg;
        service_bits_next  = service_bits_reg;
        line_state_next    = line_state_reg;
        vector_base_next   = vector_base_reg;
        phase_next         = phase_reg;
        icw4_expected_next = icw4_expected_reg;
        single_mode_next   = single_mode_reg;
        readback_isr_next  = readback_isr_reg;
        auto_eoi_next      = auto_eoi_reg;
        rd_data_next       = 8'h00;
        vector_next        = 8'h00;
        idle_next          = 1'b0;

        line_bit = 8'h01 << in_line_reg;
        ack_pick = lowest_onehot(eligible(request_bits_reg, mask_bits_reg, service_bits_reg));
        eoi_bit  = 8'h01 << in_data_reg[2:0];

        case (in_func_reg)
            FUNC_READ:
            begin
                if (in_port_reg == PORT_DATA)
                begin
                    rd_data_next = mask_bits_reg;
                end
                else
                begin
                    rd_data_next = readback_isr_reg ? service_bits_reg : request_bits_reg;
                end
            end
            FUNC_WRITE:
            begin
                if (in_port_reg == PORT_CMD)
                begin
                    if ((in_data_reg & ICW1_FLAG) != 8'h00)
                    begin
                        mask_bits_next     = 8'h00;
                        request_bits_next  = 8'h00;
                        service_bits_next  = 8'h00;
                        icw4_expected_next = in_data_reg[0];
                        single_mode_next   = in_data_reg[1];
                        phase_next         = PH_ICW2;
                    end
                    else if ((in_data_reg & OCW3_SEL_MASK) == OCW3_SEL_CODE)
                    begin
                        if (in_data_reg[1])
                        begin
                            readback_isr_next = in_data_reg[0];
                        end
                    end
                    else if ((in_data_reg & EOI_SEL_MASK) == EOI_NONSPEC)
                    begin
                        service_bits_next = service_bits_reg & ~lowest_onehot(service_bits_reg);
                    end
                    else if ((in_data_reg & EOI_SEL_MASK) == EOI_SPECIFIC)
                    begin
                        service_bits_next = service_bits_reg & ~eoi_bit;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_ICW2:
                        begin
                            vector_base_next = in_data_reg & VEC_BASE_MASK;
                            if (single_mode_reg)
                            begin
                                phase_next = icw4_expected_reg ? PH_ICW4 : PH_READY;
                            end
                            else
                            begin
                                phase_next = PH_ICW3;
                            end
                        end
                        PH_ICW3:
                        begin
                            phase_next = icw4_expected_reg ? PH_ICW4 : PH_READY;
                        end
                        PH_ICW4:
                        begin
                            auto_eoi_next = in_data_reg[1];
                            phase_next    = PH_READY;
                        end
                        default:
                        begin
                            mask_bits_next = in_data_reg;
                        end
                    endcase
                end
            end
            FUNC_LINE:
            begin
                if (in_level_reg)
                begin
                    // Only a rising edge latches a request.
                    if ((line_state_reg & line_bit) == 8'h00)
                    begin
                        request_bits_next = request_bits_reg | line_bit;
                    end
                    line_state_next = line_state_reg | line_bit;
                end
                else
                begin
                    line_state_next = line_state_reg & ~line_bit;
                    if ((service_bits_reg & line_bit) == 8'h00)
                    begin
                        request_bits_next = request_bits_reg & ~line_bit;
                    end
                end
            end
            default:
            begin
                if (ack_pick == 8'h00)
                begin
                    idle_next = 1'b1;
                end
                else
                begin
                    request_bits_next = request_bits_reg & ~ack_pick;
                    if (!auto_eoi_reg)
                    begin
                        service_bits_next = service_bits_reg | ack_pick;
                    end
                    vector_next = vector_base_reg + {5'b00000, lowest_index(ack_pick)};
                end
            end
        endcase

        int_out_next = (eligible(request_bits_next, mask_bits_next, service_bits_next)
                        != 8'h00);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_bits_reg     <= MASK_RESET;
            request_bits_reg  <= 8'h00;
            service_bits_reg  <= 8'h00;
            line_state_reg    <= 8'h00;
            vector_base_reg   <= VEC_BASE_RESET;
            phase_reg         <= PH_READY;
            icw4_expected_reg <= 1'b0;
            single_mode_reg   <= 1'b0;
            readback_isr_reg  <= 1'b0;
            auto_eoi_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mask_bits_reg     <= mask_bits_next;
                request_bits_reg  <= request_bits_next;
                service_bits_reg  <= service_bits_next;
                line_state_reg    <= line_state_next;
                vector_base_reg   <= vector_base_next;
                phase_reg         <= phase_next;
                icw4_expected_reg <= icw4_expected_next;
                single_mode_reg   <= single_mode_next;
                readback_isr_reg  <= readback_isr_next;
                auto_eoi_reg      <= auto_eoi_next;
                out_valid_reg     <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The snapshot fields are read straight from the state, which only moves on advance.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg <= rd_data_next;
            vector_reg  <= vector_next;
            idle_reg    <= idle_next;
            int_out_reg <= int_out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign read_data    = rd_data_reg;
    assign vector_out   = vector_reg;
    assign status       = idle_reg;
    assign int_pending  = int_out_reg;
    assign mask_reg     = mask_bits_reg;
    assign request_reg  = request_bits_reg;
    assign service_reg  = service_bits_reg;
    assign line_levels  = line_state_reg;

    // An acknowledge sets at most one in-service bit per word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(service_bits_reg & ~$past(service_bits_reg)))
        else $error("more than one in-service bit set in one step");

    // ICW1 clears the mask at the step that takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_func_reg == FUNC_WRITE && in_port_reg == PORT_CMD
         && in_data_reg[4]) |=> (mask_bits_reg == 8'h00 && phase_reg == PH_ICW2))
        else $error("ICW1 did not reinitialise the controller");

    // An idle acknowledge never gives a vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && idle_reg) |-> (vector_reg == 8'h00))
        else $error("vector given with idle status");

    // The vector base is always eight-aligned.
    assert property (@(posedge clk) disable iff (!rst_n)
        vector_base_reg[2:0] == 3'b000)
        else $error("vector base not aligned");

    // A new result word is loaded only from a valid input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(in_valid_reg))
        else $error("result appeared without an input word");

endmodule

// ===== dv/interrupt_controller_8259_single_tb.sv =====
// Self-checking testbench for the single 8259-style interrupt controller.
// It drives reads, writes, line changes and acknowledges against an in-bench predictor.
// Depends on pic_pkg and interrupt_controller_8259_single.
`timescale 1ns / 1ps

module interrupt_controller_8259_single_tb;
    import pic_pkg::*;

    localparam int         RUN_LIMIT     = 300000;
    localparam int         RANDOM_WORDS  = 650;
    localparam logic [7:0] ICW1_IC4      = 8'h01;
    localparam logic [7:0] ICW1_SNGL     = 8'h02;
    localparam logic [7:0] ICW4_AEOI     = 8'h02;
    localparam logic [7:0] OCW3_RR       = 8'h02;
    localparam logic [7:0] OCW3_RIS      = 8'h01;
    localparam logic [7:0] CMD_ROTATE    = 8'hc0;

    typedef struct {
        func_t      kind;
        logic       port_sel;
        logic [7:0] data;
        logic [2:0] line;
        logic       lvl;
        int         gap;
        bit         hold;
    } pic_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       status;
        logic       int_pending;
        logic [7:0] mask;
        logic [7:0] request;
        logic [7:0] service;
        logic [7:0] lines;
    } pic_response_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [1:0] func = FUNC_READ;
    logic       port = PORT_CMD;
    logic [7:0] write_data = 8'h00;
    logic [2:0] irq_line = 3'd0;
    logic       level = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] read_data;
    logic [7:0] vector_out;
    logic       status;
    logic       int_pending;
    logic [7:0] mask_reg;
    logic [7:0] request_reg;
    logic [7:0] service_reg;
    logic [7:0] line_levels;

    pic_word_t     pending_words[$];
    pic_response_t expected_responses[$];
    pic_word_t     current_word;

    // Predicted controller state.
    logic [7:0] imr_m;
    logic [7:0] irr_m;
    logic [7:0] isr_m;
    logic [7:0] lines_m;
    logic [7:0] base_m;
    phase_t     phase_m;
    logic       icw4_m;
    logic       single_m;
    logic       show_isr_m;
    logic       aeoi_m;

    bit steady_stretch = 1'b0;
    bit hold_next = 1'b0;
    int idle_wait = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int failure_count = 0;
    int responses_checked = 0;
    int reads_seen = 0;
    int writes_seen = 0;
    int line_changes_seen = 0;
    int acks_seen = 0;
    int vectors_given = 0;
    int idle_acks = 0;
    int inits_seen = 0;

    interrupt_controller_8259_single dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .port         (port),
        .write_data   (write_data),
        .irq_line     (irq_line),
        .level        (level),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .vector_out   (vector_out),
        .status       (status),
        .int_pending  (int_pending),
        .mask_reg     (mask_reg),
        .request_reg  (request_reg),
        .service_reg  (service_reg),
        .line_levels  (line_levels)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Index of the highest-priority (lowest numbered) set bit, 8 when empty.
    function automatic int first_set(input logic [7:0] v);
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                return i;
            end
        end
        return 8;
    endfunction

    function automatic logic [7:0] eligible_lines();
        logic [7:0] pend;
        int         top;
        pend = irr_m & ~imr_m;
        top = first_set(isr_m);
        if (top < 8)
        begin
            pend = pend & ((8'd1 << top) - 8'd1);
        end
        return pend;
    endfunction

    function automatic logic [7:0] sparse_mask();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 8'h00;
        end
        if (pick == 1)
        begin
            return MASK_RESET;
        end
        if (pick == 2)
        begin
            return 8'($urandom);
        end
        return 8'($urandom & $urandom & $urandom);
    endfunction

    function automatic string format_response(input pic_response_t r);
        return $sformatf("rd=%02h vec=%02h st=%0b int=%0b imr=%02h irr=%02h isr=%02h lines=%02h",
                         r.read_data, r.vector, r.status, r.int_pending, r.mask, r.request,
                         r.service, r.lines);
    endfunction

    function automatic void note_failure(input string msg);
        failure_count++;
        if (failure_count <= 10)
        begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    // Queue one word; fields the block ignores for this kind are randomised.
    task automatic add_word(input func_t kind, input logic port_sel, input logic [7:0] data,
                            input logic [2:0] line, input logic lvl);
        pic_word_t w;
        w.kind = kind;
        w.port_sel = port_sel;
        w.data = data;
        w.line = line;
        w.lvl = lvl;
        if (kind == FUNC_READ || kind == FUNC_ACK)
        begin
            w.data = 8'($urandom);
        end
        if (kind != FUNC_LINE)
        begin
            w.line = 3'($urandom);
            w.lvl = 1'($urandom);
        end
        if (kind == FUNC_LINE || kind == FUNC_ACK)
        begin
            w.port_sel = 1'($urandom);
            w.data = 8'($urandom);
        end
        w.gap = steady_stretch ? 0 : $urandom_range(0, 17);
        w.hold = hold_next;
        hold_next = 1'b0;
        pending_words.push_back(w);
    endtask

    // Well-formed initialisation: ICW1, ICW2 and, as ICW1 asks, ICW3 and ICW4.
    task automatic add_init(input logic [7:0] icw1, input logic [7:0] icw2,
                            input logic [7:0] icw4);
        add_word(FUNC_WRITE, PORT_CMD, icw1 | ICW1_FLAG, 3'd0, 1'b0);
        add_word(FUNC_WRITE, PORT_DATA, icw2, 3'd0, 1'b0);
        if ((icw1 & ICW1_SNGL) == 8'h00)
        begin
            add_word(FUNC_WRITE, PORT_DATA, 8'($urandom), 3'd0, 1'b0);
        end
        if ((icw1 & ICW1_IC4) != 8'h00)
        begin
            add_word(FUNC_WRITE, PORT_DATA, icw4, 3'd0, 1'b0);
        end
    endtask

    task automatic predict_pic_response(input pic_word_t w);
        pic_response_t r;
        int            k;
        logic [7:0]    v;
        r = '0;
        v = w.data;
        case (w.kind)
            FUNC_READ:
            begin
                reads_seen++;
                if (w.port_sel == PORT_DATA)
                begin
                    r.read_data = imr_m;
                end
                else
                begin
                    r.read_data = show_isr_m ? isr_m : irr_m;
                end
            end
            FUNC_WRITE:
            begin
                writes_seen++;
                if (w.port_sel == PORT_CMD)
                begin
                    if ((v & ICW1_FLAG) != 8'h00)
                    begin
                        inits_seen++;
                        imr_m = 8'h00;
                        irr_m = 8'h00;
                        isr_m = 8'h00;
                        icw4_m = v[0];
                        single_m = v[1];
                        phase_m = PH_ICW2;
                    end
                    else if ((v & OCW3_SEL_MASK) == OCW3_SEL_CODE)
                    begin
                        if (v[1])
                        begin
                            show_isr_m = v[0];
                        end
                    end
                    else if ((v & EOI_SEL_MASK) == EOI_NONSPEC)
                    begin
                        k = first_set(isr_m);
                        if (k < 8)
                        begin
                            isr_m[k] = 1'b0;
                        end
                    end
                    else if ((v & EOI_SEL_MASK) == EOI_SPECIFIC)
                    begin
                        isr_m[v[2:0]] = 1'b0;
                    end
                end
                else
                begin
                    case (phase_m)
                        PH_ICW2:
                        begin
                            base_m = v & VEC_BASE_MASK;
                            if (single_m)
                            begin
                                phase_m = icw4_m ? PH_ICW4 : PH_READY;
                            end
                            else
                            begin
                                phase_m = PH_ICW3;
                            end
                        end
                        PH_ICW3:
                        begin
                            phase_m = icw4_m ? PH_ICW4 : PH_READY;
                        end
                        PH_ICW4:
                        begin
                            aeoi_m = v[1];
                            phase_m = PH_READY;
                        end
                        default:
                        begin
                            imr_m = v;
                        end
                    endcase
                end
            end
            FUNC_LINE:
            begin
                line_changes_seen++;
                if (w.lvl)
                begin
                    if (!lines_m[w.line])
                    begin
                        irr_m[w.line] = 1'b1;
                    end
                    lines_m[w.line] = 1'b1;
                end
                else
                begin
                    lines_m[w.line] = 1'b0;
                    if (!isr_m[w.line])
                    begin
                        irr_m[w.line] = 1'b0;
                    end
                end
            end
            default:
            begin
                acks_seen++;
                k = first_set(eligible_lines());
                if (k == 8)
                begin
                    idle_acks++;
                    r.status = 1'b1;
                end
                else
                begin
                    vectors_given++;
                    irr_m[k] = 1'b0;
                    if (!aeoi_m)
                    begin
                        isr_m[k] = 1'b1;
                    end
                    r.vector = base_m + 8'(k);
                end
            end
        endcase
        r.int_pending = (eligible_lines() != 8'h00);
        r.mask = imr_m;
        r.request = irr_m;
        r.service = isr_m;
        r.lines = lines_m;
        expected_responses.push_back(r);
    endtask

    task automatic check_response();
        pic_response_t got;
        pic_response_t want;
        string         diffs;
        got = {read_data, vector_out, status, int_pending, mask_reg, request_reg,
               service_reg, line_levels};
        responses_checked++;
        if (expected_responses.size() == 0)
        begin
            note_failure($sformatf("unexpected result %s", format_response(got)));
            return;
        end
        want = expected_responses.pop_front();
        diffs = "";
        if (got.read_data !== want.read_data)     diffs = {diffs, " read_data"};
        if (got.vector !== want.vector)           diffs = {diffs, " vector_out"};
        if (got.status !== want.status)           diffs = {diffs, " status"};
        if (got.int_pending !== want.int_pending) diffs = {diffs, " int_pending"};
        if (got.mask !== want.mask)               diffs = {diffs, " mask_reg"};
        if (got.request !== want.request)         diffs = {diffs, " request_reg"};
        if (got.service !== want.service)         diffs = {diffs, " service_reg"};
        if (got.lines !== want.lines)             diffs = {diffs, " line_levels"};
        if (diffs != "")
        begin
            note_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                   responses_checked, diffs, format_response(want),
                                   format_response(got)));
        end
    endtask

    // Driver: presents queued words, honouring each word's idle gap and any hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            func <= FUNC_READ;
            port <= PORT_CMD;
            write_data <= 8'h00;
            irq_line <= 3'd0;
            level <= 1'b0;
            idle_wait = 0;
            imr_m = MASK_RESET;
            irr_m = 8'h00;
            isr_m = 8'h00;
            lines_m = 8'h00;
            base_m = VEC_BASE_RESET;
            phase_m = PH_READY;
            icw4_m = 1'b0;
            single_m = 1'b0;
            show_isr_m = 1'b0;
            aeoi_m = 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_pic_response(current_word);
            end
            if (!item_valid || item_ready)
            begin
                if (pending_words.size() != 0 && idle_wait < pending_words[0].gap)
                begin
                    idle_wait++;
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 &&
                         (!pending_words[0].hold || expected_responses.size() == 0))
                begin
                    current_word = pending_words.pop_front();
                    idle_wait = 0;
                    item_valid <= 1'b1;
                    func <= current_word.kind;
                    port <= current_word.port_sel;
                    write_data <= current_word.data;
                    irq_line <= current_word.line;
                    level <= current_word.lvl;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results, checks them and stalls the result side at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else if (result_valid && result_ready)
        begin
            check_response();
            stall_left = ((responses_checked / 40) % 4 == 0) ? 0 : $urandom_range(0, 17);
            result_ready <= (stall_left == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= (stall_left == 0);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_responses.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int random_count;
        int pick;

        // Directed opening: reset readback, cascaded init, nesting, EOIs, auto-EOI.
        add_word(FUNC_READ, PORT_DATA, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_READ, PORT_CMD, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd2, 1'b1);
        add_init(ICW1_IC4, 8'h27, 8'h01);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd0, 1'b1);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd3, 1'b1);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd3, 1'b1);
        add_word(FUNC_ACK, PORT_CMD, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_ACK, PORT_CMD, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_WRITE, PORT_CMD, OCW3_SEL_CODE | OCW3_RR | OCW3_RIS, 3'd0, 1'b0);
        add_word(FUNC_READ, PORT_CMD, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_WRITE, PORT_CMD, EOI_NONSPEC, 3'd0, 1'b0);
        add_word(FUNC_ACK, PORT_CMD, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd3, 1'b0);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd1, 1'b1);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd1, 1'b0);
        add_word(FUNC_WRITE, PORT_CMD, EOI_SPECIFIC | 8'h03, 3'd0, 1'b0);
        add_word(FUNC_WRITE, PORT_CMD, OCW3_SEL_CODE | OCW3_RIS, 3'd0, 1'b0);
        add_word(FUNC_WRITE, PORT_CMD, CMD_ROTATE, 3'd0, 1'b0);
        hold_next = 1'b1;
        add_init(ICW1_SNGL | ICW1_IC4, 8'hff, ICW4_AEOI);
        add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'd7, 1'b1);
        add_word(FUNC_ACK, PORT_CMD, 8'h00, 3'd0, 1'b0);
        add_word(FUNC_WRITE, PORT_DATA, MASK_RESET, 3'd0, 1'b0);

        // Random part: mostly well-formed traffic, some re-initialisation and noise.
        random_count = 0;
        while (random_count < RANDOM_WORDS)
        begin
            steady_stretch = ((random_count / 50) % 4 == 0);
            if (random_count % 100 == 99)
            begin
                hold_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                add_init(8'($urandom), 8'($urandom), 8'($urandom));
                add_word(FUNC_WRITE, PORT_DATA, sparse_mask(), 3'd0, 1'b0);
                random_count += 4;
            end
            else if (pick < 38)
            begin
                add_word(FUNC_LINE, PORT_CMD, 8'h00, 3'($urandom), 1'($urandom));
                random_count++;
            end
            else if (pick < 58)
            begin
                add_word(FUNC_ACK, PORT_CMD, 8'h00, 3'd0, 1'b0);
                random_count++;
            end
            else if (pick < 70)
            begin
                add_word(FUNC_READ, 1'($urandom), 8'h00, 3'd0, 1'b0);
                random_count++;
            end
            else if (pick < 77)
            begin
                add_word(FUNC_WRITE, PORT_DATA, sparse_mask(), 3'd0, 1'b0);
                random_count++;
            end
            else if (pick < 87)
            begin
                add_word(FUNC_WRITE, PORT_CMD,
                         ($urandom_range(0, 1) ? EOI_NONSPEC : EOI_SPECIFIC) | 8'($urandom % 8),
                         3'd0, 1'b0);
                random_count++;
            end
            else if (pick < 92)
            begin
                add_word(FUNC_WRITE, PORT_CMD, (8'($urandom) & 8'he7) | OCW3_SEL_CODE,
                         3'd0, 1'b0);
                random_count++;
            end
            else
            begin
                // Stray byte on either port; may break an initialisation sequence.
                add_word(FUNC_WRITE, 1'($urandom), 8'($urandom), 3'd0, 1'b0);
                random_count++;
            end
        end
        steady_stretch = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || item_valid || expected_responses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (expected_responses.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", expected_responses.size()));
        end
        $display("Ran %0d words: %0d reads, %0d writes, %0d line changes, %0d acknowledges",
                 reads_seen + writes_seen + line_changes_seen + acks_seen, reads_seen,
                 writes_seen, line_changes_seen, acks_seen);
        $display("%0d vectors given, %0d idle acknowledges, %0d initialisations, %0d failures",
                 vectors_given, idle_acks, inits_seen, failure_count);
        if (failure_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pic_pkg.sv
hdl/interrupt_controller_8259_single.sv
dv/interrupt_controller_8259_single_tb.sv
